>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the ARQ sender RTL.
// Every macro samples on the rising edge of clock and is off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ARQS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// expr must never be true outside reset
`define ARQS_ASSERT_NEVER(label, expr, msg) \
   `ARQS_ASSERT(label, !(expr), msg)

`endif

>>> hdl/arqs_pkg.sv
// ----------------------------------------------------------------------------
// arqs_pkg
// Types, codes and sizes shared by the stop-and-wait ARQ sender core.
// ----------------------------------------------------------------------------
package arqs_pkg;

   localparam int NUM_SENDERS = 2;
   localparam int NUM_DESTS   = 2;

   localparam int SND_IDX_W = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
   localparam int DST_IDX_W = (NUM_DESTS > 1) ? $clog2(NUM_DESTS) : 1;

   localparam int SEQ_W      = 32;
   localparam int LEN_W      = 11;
   localparam int ATT_W      = 4;
   localparam int TOT_W      = 32;
   localparam int TMO_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd225;
   localparam logic [ATT_W-1:0] RETRY_RESET   = 4'd4;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY   = 2'd1;

   // request function codes
   localparam logic [1:0] FUNC_SEND = 2'd0;
   localparam logic [1:0] FUNC_ACK  = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   typedef enum logic [2:0] {
      KIND_NOTHING = 3'd0,
      KIND_SEND    = 3'd1,
      KIND_RESEND  = 3'd2,
      KIND_ACKED   = 3'd3,
      KIND_GIVEUP  = 3'd4,
      KIND_BUSY    = 3'd5,
      KIND_IGNORED = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic               who;
      logic               to_dest;
      logic [SEQ_W-1:0]   seq;
      logic [LEN_W-1:0]   len;
      logic [ATT_W-1:0]   attempt;
      logic [TOT_W-1:0]   tx;
      logic [TOT_W-1:0]   rtx;
      logic [TOT_W-1:0]   gave;
      logic               last;
   } rsp_type;

   function automatic rsp_type make_rsp(
      input kind_type         kind,
      input logic             who,
      input logic             to_dest,
      input logic [SEQ_W-1:0] seq,
      input logic [LEN_W-1:0] len,
      input logic [ATT_W-1:0] attempt,
      input logic [TOT_W-1:0] tx,
      input logic [TOT_W-1:0] rtx,
      input logic [TOT_W-1:0] gave
   );
      rsp_type r;
      r.kind    = kind;
      r.who     = who;
      r.to_dest = to_dest;
      r.seq     = seq;
      r.len     = len;
      r.attempt = attempt;
      r.tx      = tx;
      r.rtx     = rtx;
      r.gave    = gave;
      r.last    = 1'b0;
      return r;
   endfunction

endpackage

>>> hdl/arqs_rsp_buf.sv
// ----------------------------------------------------------------------------
// arqs_rsp_buf
// Response buffer: holds the result lanes of one transaction and hands them
// out one per accepted response, lane 0 first, until the lane marked last.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arqs_rsp_buf
   import arqs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_lanes [NUM_SENDERS],
   output logic    can_load,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   rsp_type                lanes_ff [NUM_SENDERS];
   logic                   valid_ff;
   logic                   valid_in;
   logic [SND_IDX_W-1:0]   idx_ff;
   logic [SND_IDX_W-1:0]   idx_in;
   logic                   take;

   assign rsp_data  = lanes_ff[idx_ff];
   assign rsp_valid = valid_ff;
   assign take      = valid_ff && rsp_ready;
   // free once the final lane leaves in this cycle
   assign can_load  = !valid_ff || (take && rsp_data.last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (take) begin
         if (rsp_data.last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + SND_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lanes_ff <= load_lanes;
      end
   end

   `ARQS_ASSERT_NEVER(a_load_busy, load && !can_load, "load while results still pending")
   `ARQS_ASSERT(a_lane_follows, (take && !rsp_data.last) |=> rsp_valid, "missing next lane")
   `ARQS_ASSERT(a_idx_range, valid_ff |-> (int'(idx_ff) < NUM_SENDERS), "lane index out of range")

endmodule

>>> hdl/stop_and_wait_arq_sender_core.sv
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender_core
// Stop-and-wait ARQ control for several senders sharing per-destination
// sequence counters: sends, acknowledgments, timer ticks and retry handling.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is a valid/ready channel. Each transaction carries a function:
//   send request, acknowledgment arrival or one timer tick.
//   rsp_* is a valid/ready channel of results. A request or an ack gives one
//   result; a tick gives one result per sender in index order. rsp_last
//   marks the final result of each request transaction.
//   csr_* writes timeout_ticks (index 0) and retry_limit (index 1) with no
//   wait state; write only while no transaction is in flight.
// Timing:
//   A transaction lands in the input register and is processed from there
//   into the response buffer once that can load; the buffer then offers its
//   first result on rsp_*. Requests and acks sustain one per cycle while
//   rsp_ready stays high; a tick holds the response port until all
//   NUM_SENDERS of its results are taken, so its rate is set by the
//   one-result-per-cycle response port.
// Reset / stall:
//   Reset clears all senders to idle, zeroes sequence counters and totals
//   and loads timeout 225, retry limit 4. A stalled rsp_ready holds the
//   buffer; one more transaction waits in the input register, then
//   req_ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stop_and_wait_arq_sender_core
   import arqs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic                  req_sender,
   input  logic                  req_dest,
   input  logic [LEN_W-1:0]      req_pkt_len,
   input  logic [SEQ_W-1:0]      req_ack_seq,
   input  logic                  req_ack_from,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_kind,
   output logic                  rsp_who,
   output logic                  rsp_to_dest,
   output logic [SEQ_W-1:0]      rsp_seq_out,
   output logic [LEN_W-1:0]      rsp_len_out,
   output logic [ATT_W-1:0]      rsp_attempt,
   output logic [TOT_W-1:0]      rsp_transmissions,
   output logic [TOT_W-1:0]      rsp_retransmissions,
   output logic [TOT_W-1:0]      rsp_gave_up,
   output logic                  rsp_last,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---- configuration registers ----
   logic [TMO_W-1:0] timeout_ff;
   logic [ATT_W-1:0] retry_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= TIMEOUT_RESET;
         retry_limit_ff <= RETRY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT: timeout_ff     <= csr_wdata[TMO_W-1:0];
            CSR_RETRY:   retry_limit_ff <= csr_wdata[ATT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- input register ----
   logic             in_valid_ff;
   logic             in_valid_in;
   logic [1:0]       in_func_ff;
   logic             in_sender_ff;
   logic             in_dest_ff;
   logic [LEN_W-1:0] in_len_ff;
   logic [SEQ_W-1:0] in_ack_seq_ff;
   logic             in_ack_from_ff;
   logic             req_take;
   logic             can_load;
   logic             fire;

   assign req_take  = req_valid && req_ready;
   assign fire      = in_valid_ff && can_load;
   // input register frees up whenever its transaction moves to the buffer
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff     <= req_func;
         in_sender_ff   <= req_sender;
         in_dest_ff     <= req_dest;
         in_len_ff      <= req_pkt_len;
         in_ack_seq_ff  <= req_ack_seq;
         in_ack_from_ff <= req_ack_from;
      end
   end

   // ---- per-sender and per-destination state ----
   logic             busy_ff      [NUM_SENDERS];
   logic             busy_in      [NUM_SENDERS];
   logic [SEQ_W-1:0] held_seq_ff  [NUM_SENDERS];
   logic [SEQ_W-1:0] held_seq_in  [NUM_SENDERS];
   logic             held_dest_ff [NUM_SENDERS];
   logic             held_dest_in [NUM_SENDERS];
   logic [LEN_W-1:0] held_len_ff  [NUM_SENDERS];
   logic [LEN_W-1:0] held_len_in  [NUM_SENDERS];
   logic [ATT_W-1:0] retry_ff     [NUM_SENDERS];
   logic [ATT_W-1:0] retry_in     [NUM_SENDERS];
   logic [TMO_W-1:0] countdown_ff [NUM_SENDERS];
   logic [TMO_W-1:0] countdown_in [NUM_SENDERS];
   logic [TOT_W-1:0] sent_ff      [NUM_SENDERS];
   logic [TOT_W-1:0] sent_in      [NUM_SENDERS];
   logic [TOT_W-1:0] resent_ff    [NUM_SENDERS];
   logic [TOT_W-1:0] resent_in    [NUM_SENDERS];
   logic [TOT_W-1:0] dropped_ff   [NUM_SENDERS];
   logic [TOT_W-1:0] dropped_in   [NUM_SENDERS];
   logic [SEQ_W-1:0] next_seq_ff  [NUM_DESTS];
   logic [SEQ_W-1:0] next_seq_in  [NUM_DESTS];

   rsp_type          lanes        [NUM_SENDERS];

   logic [SND_IDX_W-1:0] sidx;
   logic [DST_IDX_W-1:0] didx;
   logic                 snd_ok;
   logic                 ack_hit;

   assign sidx    = SND_IDX_W'(in_sender_ff);
   // destinations beyond the table wrap around
   assign didx    = DST_IDX_W'(int'(in_dest_ff) % NUM_DESTS);
   assign snd_ok  = int'(in_sender_ff) < NUM_SENDERS;
   assign ack_hit = busy_ff[sidx] && (in_ack_seq_ff == held_seq_ff[sidx])
                    && (in_ack_from_ff == held_dest_ff[sidx]);

   always_comb begin
      busy_in      = busy_ff;
      held_seq_in  = held_seq_ff;
      held_dest_in = held_dest_ff;
      held_len_in  = held_len_ff;
      retry_in     = retry_ff;
      countdown_in = countdown_ff;
      sent_in      = sent_ff;
      resent_in    = resent_ff;
      dropped_in   = dropped_ff;
      next_seq_in  = next_seq_ff;
      for (int i = 0; i < NUM_SENDERS; i++) begin
         lanes[i] = '0;
      end

      if (fire) begin
         if (in_func_ff == FUNC_TICK) begin
            // every sender is handled in parallel, one lane each
            for (int i = 0; i < NUM_SENDERS; i++) begin
               if (!busy_ff[i]) begin
                  lanes[i] = make_rsp(KIND_NOTHING, 1'(i), 1'b0, '0, '0, '0,
                                      sent_ff[i], resent_ff[i], dropped_ff[i]);
               end else if (countdown_ff[i] > TMO_W'(1)) begin
                  countdown_in[i] = countdown_ff[i] - TMO_W'(1);
                  lanes[i] = make_rsp(KIND_NOTHING, 1'(i), held_dest_ff[i],
                                      held_seq_ff[i], held_len_ff[i], retry_ff[i],
                                      sent_ff[i], resent_ff[i], dropped_ff[i]);
               end else if (retry_ff[i] < retry_limit_ff) begin
                  retry_in[i]     = retry_ff[i] + ATT_W'(1);
                  resent_in[i]    = resent_ff[i] + TOT_W'(1);
                  sent_in[i]      = sent_ff[i] + TOT_W'(1);
                  countdown_in[i] = timeout_ff;
                  lanes[i] = make_rsp(KIND_RESEND, 1'(i), held_dest_ff[i],
                                      held_seq_ff[i], held_len_ff[i], retry_in[i],
                                      sent_in[i], resent_in[i], dropped_ff[i]);
               end else begin
                  dropped_in[i]   = dropped_ff[i] + TOT_W'(1);
                  busy_in[i]      = 1'b0;
                  retry_in[i]     = '0;
                  countdown_in[i] = '0;
                  lanes[i] = make_rsp(KIND_GIVEUP, 1'(i), held_dest_ff[i],
                                      held_seq_ff[i], held_len_ff[i], retry_ff[i],
                                      sent_ff[i], resent_ff[i], dropped_in[i]);
               end
            end
            lanes[NUM_SENDERS-1].last = 1'b1;
         end else begin
            if (!snd_ok || (in_func_ff != FUNC_SEND && in_func_ff != FUNC_ACK)) begin
               lanes[0] = '0;
            end else if (in_func_ff == FUNC_SEND) begin
               if (busy_ff[sidx]) begin
                  lanes[0] = make_rsp(KIND_BUSY, in_sender_ff, held_dest_ff[sidx],
                                      held_seq_ff[sidx], held_len_ff[sidx],
                                      retry_ff[sidx], sent_ff[sidx],
                                      resent_ff[sidx], dropped_ff[sidx]);
               end else begin
                  held_seq_in[sidx]  = next_seq_ff[didx];
                  next_seq_in[didx]  = next_seq_ff[didx] + SEQ_W'(1);
                  held_dest_in[sidx] = 1'(didx);
                  held_len_in[sidx]  = in_len_ff;
                  retry_in[sidx]     = '0;
                  countdown_in[sidx] = timeout_ff;
                  busy_in[sidx]      = 1'b1;
                  sent_in[sidx]      = sent_ff[sidx] + TOT_W'(1);
                  lanes[0] = make_rsp(KIND_SEND, in_sender_ff, 1'(didx),
                                      next_seq_ff[didx], in_len_ff, '0,
                                      sent_in[sidx], resent_ff[sidx],
                                      dropped_ff[sidx]);
               end
            end else begin
               if (ack_hit) begin
                  busy_in[sidx]      = 1'b0;
                  retry_in[sidx]     = '0;
                  countdown_in[sidx] = '0;
                  lanes[0] = make_rsp(KIND_ACKED, in_sender_ff, held_dest_ff[sidx],
                                      held_seq_ff[sidx], held_len_ff[sidx],
                                      retry_ff[sidx], sent_ff[sidx],
                                      resent_ff[sidx], dropped_ff[sidx]);
               end else begin
                  lanes[0] = make_rsp(KIND_IGNORED, in_sender_ff, in_ack_from_ff,
                                      in_ack_seq_ff, '0, '0, sent_ff[sidx],
                                      resent_ff[sidx], dropped_ff[sidx]);
               end
            end
            lanes[0].last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SENDERS; i++) begin
            busy_ff[i]      <= 1'b0;
            held_seq_ff[i]  <= '0;
            held_dest_ff[i] <= 1'b0;
            held_len_ff[i]  <= '0;
            retry_ff[i]     <= '0;
            countdown_ff[i] <= '0;
            sent_ff[i]      <= '0;
            resent_ff[i]    <= '0;
            dropped_ff[i]   <= '0;
         end
         for (int d = 0; d < NUM_DESTS; d++) begin
            next_seq_ff[d] <= '0;
         end
      end else begin
         busy_ff      <= busy_in;
         held_seq_ff  <= held_seq_in;
         held_dest_ff <= held_dest_in;
         held_len_ff  <= held_len_in;
         retry_ff     <= retry_in;
         countdown_ff <= countdown_in;
         sent_ff      <= sent_in;
         resent_ff    <= resent_in;
         dropped_ff   <= dropped_in;
         next_seq_ff  <= next_seq_in;
      end
   end

   // ---- response buffer ----
   rsp_type rsp_data;

   arqs_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .load_lanes (lanes),
      .can_load   (can_load),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_kind            = rsp_data.kind;
   assign rsp_who             = rsp_data.who;
   assign rsp_to_dest         = rsp_data.to_dest;
   assign rsp_seq_out         = rsp_data.seq;
   assign rsp_len_out         = rsp_data.len;
   assign rsp_attempt         = rsp_data.attempt;
   assign rsp_transmissions   = rsp_data.tx;
   assign rsp_retransmissions = rsp_data.rtx;
   assign rsp_gave_up         = rsp_data.gave;
   assign rsp_last            = rsp_data.last;

   // ---- checks ----
   `ARQS_ASSERT(a_in_captured, req_take |=> in_valid_ff, "accepted transaction not held")
   `ARQS_ASSERT(a_in_stall, (in_valid_ff && !can_load) |-> !req_ready, "ready while input register stalled")

   for (genvar g = 0; g < NUM_SENDERS; g++) begin : g_idle_chk
      `ARQS_ASSERT(a_idle_clean, !busy_ff[g] |-> (countdown_ff[g] == '0 && retry_ff[g] == '0), "idle sender keeps timer or retries")
   end

endmodule

>>> bench/tb_stop_and_wait_arq_sender_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stop_and_wait_arq_sender_core
// Self-checking bench for the stop-and-wait ARQ sender core. A behavioral
// predictor tracks every sender's held packet, timers, retries and totals,
// plus the shared per-destination sequence counters. It queues the results
// each accepted request transaction should produce. A checker compares every
// response transaction field by field against the oldest queued result.
// Stimulus is a short directed pass followed by random traffic. The random
// traffic runs under several timeout and retry settings, with random gaps on
// both channels and a long response hold-off.
// ----------------------------------------------------------------------------
module tb_stop_and_wait_arq_sender_core;
   import arqs_pkg::*;

   // the function field has one code the block does not define
   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

   localparam int HOLD_OFF_CYCLES = 300;   // long response stall
   localparam int SETTLE_CYCLES   = 4;     // settle time after the queue drains
   localparam int WATCHDOG_LIMIT  = 3000;  // cycles without any transaction

   typedef struct packed {
      logic [1:0]       func;
      logic             sender;
      logic             dest;
      logic [LEN_W-1:0] pkt_len;
      logic [SEQ_W-1:0] ack_seq;
      logic             ack_from;
   } arq_req_type;

   // ------------------------------------------------------------------------
   // DUT signals
   // ------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_func;
   logic                  req_sender;
   logic                  req_dest;
   logic [LEN_W-1:0]      req_pkt_len;
   logic [SEQ_W-1:0]      req_ack_seq;
   logic                  req_ack_from;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [2:0]            rsp_kind;
   logic                  rsp_who;
   logic                  rsp_to_dest;
   logic [SEQ_W-1:0]      rsp_seq_out;
   logic [LEN_W-1:0]      rsp_len_out;
   logic [ATT_W-1:0]      rsp_attempt;
   logic [TOT_W-1:0]      rsp_transmissions;
   logic [TOT_W-1:0]      rsp_retransmissions;
   logic [TOT_W-1:0]      rsp_gave_up;
   logic                  rsp_last;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   stop_and_wait_arq_sender_core uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_sender          (req_sender),
      .req_dest            (req_dest),
      .req_pkt_len         (req_pkt_len),
      .req_ack_seq         (req_ack_seq),
      .req_ack_from        (req_ack_from),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_who             (rsp_who),
      .rsp_to_dest         (rsp_to_dest),
      .rsp_seq_out         (rsp_seq_out),
      .rsp_len_out         (rsp_len_out),
      .rsp_attempt         (rsp_attempt),
      .rsp_transmissions   (rsp_transmissions),
      .rsp_retransmissions (rsp_retransmissions),
      .rsp_gave_up         (rsp_gave_up),
      .rsp_last            (rsp_last),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor state: a mirror of the block's registers
   // ------------------------------------------------------------------------
   logic [TMO_W-1:0] cfg_timeout;
   logic [ATT_W-1:0] cfg_retry_limit;

   logic             busy_q      [NUM_SENDERS];
   logic [SEQ_W-1:0] held_seq_q  [NUM_SENDERS];
   logic             held_dest_q [NUM_SENDERS];
   logic [LEN_W-1:0] held_len_q  [NUM_SENDERS];
   logic [ATT_W-1:0] retries_q   [NUM_SENDERS];
   logic [TMO_W-1:0] countdown_q [NUM_SENDERS];
   logic [TOT_W-1:0] sent_cnt    [NUM_SENDERS];
   logic [TOT_W-1:0] resent_cnt  [NUM_SENDERS];
   logic [TOT_W-1:0] dropped_cnt [NUM_SENDERS];
   logic [SEQ_W-1:0] next_seq_q  [NUM_DESTS];

   // results still owed by the block, oldest first
   rsp_type pending_results[$];

   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   bit  idling_on      = 1'b1;   // random gaps on both channels
   int  hold_off_left  = 0;      // receiver stall requested by a test

   function automatic void clear_predictor();
      cfg_timeout     = TIMEOUT_RESET;
      cfg_retry_limit = RETRY_RESET;
      for (int i = 0; i < NUM_SENDERS; i++) begin
         busy_q[i]      = 1'b0;
         held_seq_q[i]  = '0;
         held_dest_q[i] = 1'b0;
         held_len_q[i]  = '0;
         retries_q[i]   = '0;
         countdown_q[i] = '0;
         sent_cnt[i]    = '0;
         resent_cnt[i]  = '0;
         dropped_cnt[i] = '0;
      end
      for (int i = 0; i < NUM_DESTS; i++)
         next_seq_q[i] = '0;
   endfunction

   function automatic rsp_type make_result(kind_type kind, logic s, logic d,
                                           logic [SEQ_W-1:0] seq,
                                           logic [LEN_W-1:0] len,
                                           logic [ATT_W-1:0] att,
                                           bit with_totals);
      rsp_type r;
      r.kind    = kind;
      r.who     = s;
      r.to_dest = d;
      r.seq     = seq;
      r.len     = len;
      r.attempt = att;
      r.tx      = with_totals ? sent_cnt[s]    : '0;
      r.rtx     = with_totals ? resent_cnt[s]  : '0;
      r.gave    = with_totals ? dropped_cnt[s] : '0;
      r.last    = 1'b0;
      return r;
   endfunction

   // result that reports the packet a sender currently holds
   function automatic rsp_type held_result(kind_type kind, logic s);
      return make_result(kind, s, held_dest_q[s], held_seq_q[s], held_len_q[s],
                         retries_q[s], 1'b1);
   endfunction

   // one timer tick for one sender
   function automatic rsp_type tick_sender(logic s);
      rsp_type r;
      if (!busy_q[s])
         return make_result(KIND_NOTHING, s, 1'b0, '0, '0, '0, 1'b1);
      if (countdown_q[s] > TMO_W'(1)) begin
         countdown_q[s] = countdown_q[s] - TMO_W'(1);
         return held_result(KIND_NOTHING, s);
      end
      // expired: a countdown of 0 counts as expired too
      if (retries_q[s] < cfg_retry_limit) begin
         retries_q[s]   = retries_q[s] + ATT_W'(1);
         resent_cnt[s]  = resent_cnt[s] + TOT_W'(1);
         sent_cnt[s]    = sent_cnt[s] + TOT_W'(1);
         countdown_q[s] = cfg_timeout;
         return held_result(KIND_RESEND, s);
      end
      dropped_cnt[s] = dropped_cnt[s] + TOT_W'(1);
      r = held_result(KIND_GIVEUP, s);
      busy_q[s]      = 1'b0;
      retries_q[s]   = '0;
      countdown_q[s] = '0;
      return r;
   endfunction

   // queue the results one accepted request transaction must produce
   function automatic void predict_arq_results(arq_req_type q);
      rsp_type r;
      logic    s;
      logic    d;
      s = q.sender;
      d = q.dest;
      case (q.func)
         FUNC_TICK: begin
            // one result per sender, in index order
            for (int i = 0; i < NUM_SENDERS - 1; i++)
               pending_results.push_back(tick_sender(i[0]));
            r = tick_sender(1'(NUM_SENDERS - 1));
         end
         FUNC_SEND: begin
            if (busy_q[s]) begin
               r = held_result(KIND_BUSY, s);
            end else begin
               held_seq_q[s]  = next_seq_q[d];
               next_seq_q[d]  = next_seq_q[d] + SEQ_W'(1);
               held_dest_q[s] = d;
               held_len_q[s]  = q.pkt_len;
               retries_q[s]   = '0;
               countdown_q[s] = cfg_timeout;
               busy_q[s]      = 1'b1;
               sent_cnt[s]    = sent_cnt[s] + TOT_W'(1);
               r = held_result(KIND_SEND, s);
            end
         end
         FUNC_ACK: begin
            if (busy_q[s] && q.ack_seq == held_seq_q[s] && q.ack_from == held_dest_q[s]) begin
               r = held_result(KIND_ACKED, s);
               busy_q[s]      = 1'b0;
               retries_q[s]   = '0;
               countdown_q[s] = '0;
            end else begin
               r = make_result(KIND_IGNORED, s, q.ack_from, q.ack_seq, '0, '0, 1'b1);
            end
         end
         default: r = make_result(KIND_NOTHING, 1'b0, 1'b0, '0, '0, '0, 1'b0);
      endcase
      r.last = 1'b1;
      pending_results.push_back(r);
   endfunction

   // ------------------------------------------------------------------------
   // Reporting and checking
   // ------------------------------------------------------------------------
   task automatic report(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // every response transaction is held against the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result: kind %0d who %0d", rsp_kind, rsp_who));
         end else begin
            want = pending_results.pop_front();
            check_field("kind", 32'(rsp_kind), 32'(want.kind));
            check_field("who", 32'(rsp_who), 32'(want.who));
            check_field("to_dest", 32'(rsp_to_dest), 32'(want.to_dest));
            check_field("seq_out", rsp_seq_out, want.seq);
            check_field("len_out", 32'(rsp_len_out), 32'(want.len));
            check_field("attempt", 32'(rsp_attempt), 32'(want.attempt));
            check_field("transmissions", rsp_transmissions, want.tx);
            check_field("retransmissions", rsp_retransmissions, want.rtx);
            check_field("gave_up", rsp_gave_up, want.gave);
            check_field("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   // watchdog: a hang shows up as a long run of cycles with no transaction
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Idling: mostly no gap, some short, a few long
   // ------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (!idling_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // receiver: random stalls, plus the long hold-off a test can ask for
   initial begin : drive_rsp_ready
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_ready <= 1'b0;
            hold_off_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   // drives one request transaction, waits for it to be taken, then predicts
   task automatic send_request(input arq_req_type q);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_func     <= q.func;
      req_sender   <= q.sender;
      req_dest     <= q.dest;
      req_pkt_len  <= q.pkt_len;
      req_ack_seq  <= q.ack_seq;
      req_ack_from <= q.ack_from;
      req_valid    <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_arq_results(q);
   endtask

   task automatic send_fields(input logic [1:0] func, input logic sender,
                              input logic dest, input logic [LEN_W-1:0] len,
                              input logic [SEQ_W-1:0] aseq, input logic afrom);
      arq_req_type q;
      q.func     = func;
      q.sender   = sender;
      q.dest     = dest;
      q.pkt_len  = len;
      q.ack_seq  = aseq;
      q.ack_from = afrom;
      send_request(q);
   endtask

   // mostly well-formed traffic: sends, matching acks and ticks; the rest is
   // stale or wrong acks and unknown functions
   function automatic arq_req_type random_request();
      arq_req_type q;
      int          pick;
      int          sel;
      q.func     = 2'($urandom);
      q.sender   = 1'($urandom);
      q.dest     = 1'($urandom);
      q.pkt_len  = LEN_W'($urandom);
      q.ack_seq  = $urandom;
      q.ack_from = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 6)
         q.pkt_len = pick[0] ? '1 : '0;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         q.func = FUNC_SEND;
      end else if (pick < 55) begin
         q.func = FUNC_ACK;
         if (busy_q[q.sender]) begin
            sel = $urandom_range(0, 7);
            q.ack_seq  = held_seq_q[q.sender];
            q.ack_from = held_dest_q[q.sender];
            if (sel == 6)
               q.ack_from = ~held_dest_q[q.sender];   // right number, wrong source
            else if (sel == 7)
               q.ack_seq = held_seq_q[q.sender] + SEQ_W'(1);
         end
      end else if (pick < 96) begin
         q.func = FUNC_TICK;
      end else begin
         q.func = FUNC_UNKNOWN;
      end
      return q;
   endfunction

   task automatic run_random(input int count);
      repeat (count) send_request(random_request());
   endtask

   // stop offering and let every owed result come out
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_TIMEOUT)
         cfg_timeout = data;
      else if (idx == CSR_RETRY)
         cfg_retry_limit = data[ATT_W-1:0];
   endtask

   // registers change only with the block idle
   task automatic configure(input logic [TMO_W-1:0] timeout,
                            input logic [ATT_W-1:0] retries);
      logic [CSR_DATA_W-1:0] retry_word;
      wait_drained();
      write_register(CSR_TIMEOUT, timeout);
      retry_word = CSR_DATA_W'($urandom);   // upper bits are don't-care
      retry_word[ATT_W-1:0] = retries;
      write_register(CSR_RETRY, retry_word);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Walks through every function and special case from reset
   task automatic test_directed_cases();
      // reset settings: timeout 225, retry limit 4
      send_fields(FUNC_TICK, 1'b0, 1'b0, '0, '0, 1'b0);          // both idle
      send_fields(FUNC_SEND, 1'b0, 1'b0, '0, '0, 1'b0);          // shortest packet
      send_fields(FUNC_SEND, 1'b0, 1'b1, 11'd5, '0, 1'b0);       // refused, sender busy
      send_fields(FUNC_SEND, 1'b1, 1'b1, '1, '0, 1'b0);          // longest packet
      send_fields(FUNC_TICK, 1'b0, 1'b0, '0, '0, 1'b0);          // countdown, no expiry
      send_fields(FUNC_ACK, 1'b0, 1'b0, '0, 32'd1, 1'b0);        // wrong number
      send_fields(FUNC_ACK, 1'b0, 1'b0, '0, 32'd0, 1'b1);        // wrong source
      send_fields(FUNC_ACK, 1'b0, 1'b0, '0, 32'd0, 1'b0);        // taken
      send_fields(FUNC_ACK, 1'b0, 1'b0, '0, 32'd0, 1'b0);        // sender idle now
      send_fields(FUNC_UNKNOWN, 1'b1, 1'b1, '1, '1, 1'b1);       // undefined function
      send_fields(FUNC_SEND, 1'b0, 1'b1, 11'd1024, '0, 1'b0);    // shared dest counter
      send_fields(FUNC_ACK, 1'b1, 1'b0, '0, 32'd0, 1'b1);
      send_fields(FUNC_ACK, 1'b0, 1'b0, '0, 32'd1, 1'b1);

      // zero timeout acts as one tick: resend, then give up at the limit
      configure(16'd0, 4'd1);
      send_fields(FUNC_SEND, 1'b0, 1'b0, 11'd5, '0, 1'b0);
      send_fields(FUNC_TICK, 1'b0, 1'b0, '0, '0, 1'b0);
      send_fields(FUNC_TICK, 1'b0, 1'b0, '0, '0, 1'b0);
      send_fields(FUNC_ACK, 1'b0, 1'b0, '0, 32'd1, 1'b0);        // too late
      send_fields(FUNC_ACK, 1'b1, 1'b0, '0, '1, 1'b1);

      // no retries allowed: give up on the first expiry
      configure(16'd2, 4'd0);
      send_fields(FUNC_SEND, 1'b1, 1'b0, 11'd100, '0, 1'b0);
      send_fields(FUNC_TICK, 1'b0, 1'b0, '0, '0, 1'b0);
      send_fields(FUNC_TICK, 1'b0, 1'b0, '0, '0, 1'b0);
   endtask

   // receiver stops for a long stretch while requests keep coming, then the
   // sender stops until everything owed has come out
   task automatic test_backpressure();
      configure(16'd5, 4'd3);
      idling_on     = 1'b0;
      hold_off_left = HOLD_OFF_CYCLES;
      run_random(40);
      wait_drained();
      run_random(30);
      idling_on = 1'b1;
   endtask

   task automatic test_mixed_traffic();
      configure(16'd3, 4'd2);
      run_random(500);
   endtask

   task automatic test_fast_timeout_max_retries();
      configure(16'd1, 4'd15);
      run_random(250);
   endtask

   // back to back, no gaps on either side
   task automatic test_zero_timeout_no_idling();
      configure(16'd0, 4'd0);
      idling_on = 1'b0;
      run_random(200);
      idling_on = 1'b1;
   endtask

   task automatic test_moderate_timeout();
      configure(16'd7, 4'd4);
      run_random(250);
   endtask

   // timers never run out here; held packets are released only by acks
   task automatic test_longest_timeout();
      configure(16'hFFFF, 4'd15);
      run_random(60);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_func     = FUNC_SEND;
      req_sender   = 1'b0;
      req_dest     = 1'b0;
      req_pkt_len  = '0;
      req_ack_seq  = '0;
      req_ack_from = 1'b0;
      csr_we       = 1'b0;
      csr_index    = CSR_TIMEOUT;
      csr_wdata    = '0;
      clear_predictor();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_backpressure();
      test_mixed_traffic();
      test_fast_timeout_max_retries();
      test_zero_timeout_no_idling();
      test_moderate_timeout();
      test_longest_timeout();

      wait_drained();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);   // catch stray results
      if (pending_results.size() != 0)
         report($sformatf("%0d results never arrived", pending_results.size()));
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
